// ===== sv/rgb_to_hsv_8bit_assert.svh =====
// Assertion macros shared by the rgb_to_hsv_8bit RTL files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RGB_TO_HSV_8BIT_ASSERT_SVH
`define RGB_TO_HSV_8BIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHSV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rhsv_pkg.sv =====
// Shared types and constants for the rgb_to_hsv_8bit block.
// Used by every RTL module of the block; depends on nothing.
package rhsv_pkg;

  // Field and datapath widths.
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned QUOT_W    = 8;
  localparam int unsigned SAT_NUM_W = 16;
  localparam int unsigned HUE_DEN_W = 11;
  localparam int unsigned HUE_NUM_W = HUE_DEN_W + CHAN_W;
  localparam int unsigned POS_W     = HUE_DEN_W + 1;

  // Input word: one RGB pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  // Output word: one HSV pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] hue_out;
    logic [CHAN_W-1:0] saturation_out;
    logic [CHAN_W-1:0] brightness_out;
  } hsv_t;

  // Which channel holds the maximum; blue wins ties, then green.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Working state handed from one divider cell to the next.
  typedef struct packed {
    logic                 sat_zero;
    logic                 hue_zero;
    logic [CHAN_W-1:0]    brightness;
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [CHAN_W-1:0]    sat_den;
    logic [QUOT_W-1:0]    sat_quot;
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [HUE_DEN_W-1:0] hue_den;
    logic [QUOT_W-1:0]    hue_quot;
  } div_t;

endpackage

// ===== sv/rhsv_front.sv =====
// Front end of the rgb_to_hsv_8bit pipeline: max/min search, sector choice
// and the numerators and denominators of both divisions. Uses rhsv_pkg.
module rhsv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rhsv_pkg::pixel_t pixel_i,
  output logic            valid_o,
  output rhsv_pkg::div_t  stage_o
);

  localparam int unsigned CW = rhsv_pkg::CHAN_W;
  localparam int unsigned PW = rhsv_pkg::POS_W;

  logic [CW-1:0]     max_c;
  logic [CW-1:0]     min_c;
  rhsv_pkg::sector_e sector_c;

  logic                 s1_valid_q;
  rhsv_pkg::pixel_t     s1_pix_q;
  logic [CW-1:0]        s1_max_q;
  logic [CW-1:0]        s1_diff_q;
  rhsv_pkg::sector_e    s1_sector_q;

  logic [PW-1:0] d_ext;
  logic [PW-1:0] r_ext;
  logic [PW-1:0] g_ext;
  logic [PW-1:0] b_ext;
  logic [PW-1:0] pos_raw;
  logic [PW-1:0] pos_wrap;
  logic [PW-1:0] pos_sel;
  logic [rhsv_pkg::HUE_DEN_W-1:0] pos_c;
  rhsv_pkg::div_t stage_c;

  logic           valid_q;
  rhsv_pkg::div_t stage_q;

  // Largest and smallest channel, and the sector of the largest.
  always_comb begin
    max_c = pixel_i.red_in;
    if (pixel_i.green_in > max_c) max_c = pixel_i.green_in;
    if (pixel_i.blue_in > max_c) max_c = pixel_i.blue_in;
    min_c = pixel_i.red_in;
    if (pixel_i.green_in < min_c) min_c = pixel_i.green_in;
    if (pixel_i.blue_in < min_c) min_c = pixel_i.blue_in;
    if (pixel_i.blue_in == max_c) begin
      sector_c = rhsv_pkg::SEC_BLUE;
    end else if (pixel_i.green_in == max_c) begin
      sector_c = rhsv_pkg::SEC_GREEN;
    end else begin
      sector_c = rhsv_pkg::SEC_RED;
    end
  end

  // First stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q    <= pixel_i;
      s1_max_q    <= max_c;
      s1_diff_q   <= max_c - min_c;
      s1_sector_q <= sector_c;
    end
  end

  // Hue position in units of the channel spread, wrapped into 0 .. 6*d-1.
  assign d_ext = PW'(s1_diff_q);
  assign r_ext = PW'(s1_pix_q.red_in);
  assign g_ext = PW'(s1_pix_q.green_in);
  assign b_ext = PW'(s1_pix_q.blue_in);

  always_comb begin
    case (s1_sector_q)
      rhsv_pkg::SEC_BLUE:  pos_raw = (d_ext << 2) + r_ext - g_ext;
      rhsv_pkg::SEC_GREEN: pos_raw = (d_ext << 1) + b_ext - r_ext;
      default:             pos_raw = g_ext - b_ext;
    endcase
  end

  assign pos_wrap = pos_raw + (d_ext << 2) + (d_ext << 1);
  assign pos_sel  = pos_raw[PW-1] ? pos_wrap : pos_raw;
  assign pos_c    = pos_sel[rhsv_pkg::HUE_DEN_W-1:0];

  // Numerators are scaled by 255 as (x << 8) - x.
  always_comb begin
    stage_c.sat_zero   = (s1_max_q == '0);
    stage_c.hue_zero   = (s1_diff_q == '0);
    stage_c.brightness = s1_max_q;
    stage_c.sat_rem    = {s1_diff_q, 8'b0} - rhsv_pkg::SAT_NUM_W'(s1_diff_q);
    stage_c.sat_den    = s1_max_q;
    stage_c.sat_quot   = '0;
    stage_c.hue_rem    = {pos_c, 8'b0} - rhsv_pkg::HUE_NUM_W'(pos_c);
    stage_c.hue_den    = rhsv_pkg::HUE_DEN_W'({s1_diff_q, 2'b00})
                       + rhsv_pkg::HUE_DEN_W'({s1_diff_q, 1'b0});
    stage_c.hue_quot   = '0;
  end

  // Second stage registers feed the first divider cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_c;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== sv/rhsv_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit of both the
// saturation and the hue division and registers the result. Uses rhsv_pkg.
module rhsv_div_cell #(
  parameter int unsigned STEP = rhsv_pkg::QUOT_W - 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rhsv_pkg::div_t stage_i,
  output logic           valid_o,
  output rhsv_pkg::div_t stage_o
);

  logic [rhsv_pkg::SAT_NUM_W-1:0] sat_sh;
  logic [rhsv_pkg::HUE_NUM_W-1:0] hue_sh;
  logic                           sat_ge;
  logic                           hue_ge;
  rhsv_pkg::div_t                 stage_c;

  logic           valid_q;
  rhsv_pkg::div_t stage_q;

  // Compare the remainder against the divisor weighted by this bit.
  assign sat_sh = rhsv_pkg::SAT_NUM_W'(stage_i.sat_den) << STEP;
  assign hue_sh = rhsv_pkg::HUE_NUM_W'(stage_i.hue_den) << STEP;
  assign sat_ge = (stage_i.sat_rem >= sat_sh);
  assign hue_ge = (stage_i.hue_rem >= hue_sh);

  always_comb begin
    stage_c = stage_i;
    if (sat_ge) begin
      stage_c.sat_rem = stage_i.sat_rem - sat_sh;
    end
    if (hue_ge) begin
      stage_c.hue_rem = stage_i.hue_rem - hue_sh;
    end
    stage_c.sat_quot[STEP] = sat_ge;
    stage_c.hue_quot[STEP] = hue_ge;
  end

  // Hand the word on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_c;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== sv/rhsv_out.sv =====
// Output stage of rgb_to_hsv_8bit: final result formatting, output register
// and one-entry skid buffer. Uses rhsv_pkg and rgb_to_hsv_8bit_assert.svh.
`include "rgb_to_hsv_8bit_assert.svh"

module rhsv_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rhsv_pkg::div_t  stage_i,
  output logic            en_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rhsv_pkg::hsv_t  out_hsv_o
);

  rhsv_pkg::hsv_t hsv_c;
  logic           arrive;
  logic           take;

  logic           out_valid_q;
  rhsv_pkg::hsv_t out_hsv_q;
  logic           skid_valid_q;
  rhsv_pkg::hsv_t skid_hsv_q;

  // A zero divisor means black or grey; those results are forced to zero.
  always_comb begin
    hsv_c.hue_out        = stage_i.hue_zero ? '0 : stage_i.hue_quot;
    hsv_c.saturation_out = stage_i.sat_zero ? '0 : stage_i.sat_quot;
    hsv_c.brightness_out = stage_i.brightness;
  end

  // The pipeline only moves while the skid entry is free.
  assign en_o   = !skid_valid_q;
  assign arrive = valid_i && en_o;
  assign take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= arrive;
    end else if (arrive) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload moves with the same decisions as the valid flags above.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_hsv_q <= skid_hsv_q;
      end
    end else if (!out_valid_q || take) begin
      if (arrive) begin
        out_hsv_q <= hsv_c;
      end
    end else if (arrive) begin
      skid_hsv_q <= hsv_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hsv_o   = out_hsv_q;

  // A buffered word always sits behind a held output word.
  `RHSV_ASSERT_SAME(skid_behind_out_a, skid_valid_q, out_valid_q, "skid word without output word")
  // A taken output word is replaced by the buffered one at once.
  `RHSV_ASSERT_NEXT(skid_drains_a, skid_valid_q && !out_stall_i, out_valid_q && !skid_valid_q, "skid word not moved to output")
  // Black pixels carry neither hue nor saturation.
  `RHSV_ASSERT_SAME(black_zero_a, out_valid_q && out_hsv_q.brightness_out == '0, out_hsv_q.saturation_out == '0 && out_hsv_q.hue_out == '0, "black pixel with hue or saturation")

endmodule

// ===== sv/rgb_to_hsv_8bit.sv =====
// rgb_to_hsv_8bit: converts 8-bit RGB pixels into 8-bit hue, saturation and
// brightness. Uses rhsv_pkg, rhsv_front, rhsv_div_cell and rhsv_out.
//
// Input channel: in_valid_i, in_stall_o and in_pixel_i. A word is taken at
// a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o, out_stall_i and out_hsv_o. A word leaves at
// a rising edge where out_valid_o is high and out_stall_i is low.
// Throughput is one pixel per clock while in_stall_o is low. The accepting
// edge loads the first of two front stages (max/min and numerators), then
// come eight divider cells that each settle one bit of both quotients, and
// the output register.
// When the receiver stalls, the output word holds and one more word lands in
// a skid entry; the pipeline then freezes and in_stall_o rises until the
// receiver takes the held word. in_stall_o comes straight from a register.
// Reset empties the pipeline and both output registers; no pixel is lost or
// repeated after it.
module rgb_to_hsv_8bit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rhsv_pkg::pixel_t in_pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rhsv_pkg::hsv_t   out_hsv_o
);

  localparam int unsigned NCELL = rhsv_pkg::QUOT_W;

  logic           pipe_en;
  logic           chain_valid [NCELL+1];
  rhsv_pkg::div_t chain_stage [NCELL+1];

  // Input stall follows the skid entry.
  assign in_stall_o = !pipe_en;

  // Max/min and numerator stages.
  rhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .pixel_i (in_pixel_i),
    .valid_o (chain_valid[0]),
    .stage_o (chain_stage[0])
  );

  // Divider cells, most significant quotient bit first.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rhsv_div_cell #(
      .STEP (NCELL - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (chain_valid[i]),
      .stage_i (chain_stage[i]),
      .valid_o (chain_valid[i+1]),
      .stage_o (chain_stage[i+1])
    );
  end

  // Result formatting, output register and skid entry.
  rhsv_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[NCELL]),
    .stage_i     (chain_stage[NCELL]),
    .en_o        (pipe_en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_hsv_o   (out_hsv_o)
  );

endmodule
